[design/c8x_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and opcode names for the CHIP-8 style execute core.
// No dependencies; every other design file except c8x_ram imports this package.
package c8x_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SIDX_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    localparam int PC_W   = 12;
    localparam int REG_W  = 8;
    localparam int RIDX_W = 4;
    localparam int NREGS  = 16;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    localparam logic [PC_W-1:0]   RESET_START = 12'h200;
    localparam logic [RIDX_W-1:0] REG_V0      = 4'h0;
    localparam logic [RIDX_W-1:0] REG_VF      = 4'hF;

    // Instruction groups (top nibble)
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEI  = 4'h3;
    localparam logic [3:0] OP_SNEI = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LDI  = 4'h6;
    localparam logic [3:0] OP_ADDI = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_LDX  = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;

    // Group zero sub-codes (low nibble)
    localparam logic [3:0] SYS_CLS = 4'h0;
    localparam logic [3:0] SYS_RET = 4'hE;

    // Register-register sub-codes (low nibble of group 8)
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic [PC_W-1:0]   index_value;
        logic              clear_display;
        logic              unknown_op;
        logic              stack_error;
        logic              dest_written;
        logic [RIDX_W-1:0] dest_index;
        logic [REG_W-1:0]  dest_value;
        logic              flag_written;
        logic              flag_value;
    } c8x_result_t;

    typedef struct packed {
        logic              dest_we;
        logic [RIDX_W-1:0] dest_idx;
        logic [REG_W-1:0]  dest_val;
        logic              flag_we;
        logic              flag_val;
    } c8x_rf_wr_t;

    typedef struct packed {
        logic            push;
        logic            pop;
        logic [PC_W-1:0] push_data;
    } c8x_stk_ctl_t;

    typedef struct packed {
        logic            empty;
        logic            full;
        logic [PC_W-1:0] top;
    } c8x_stk_stat_t;

    typedef struct packed {
        c8x_result_t  res;
        c8x_rf_wr_t   rf;
        c8x_stk_ctl_t stk;
    } c8x_exec_t;

endpackage

[design/c8x_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[design/c8x_regfile.sv]
`timescale 1ns / 1ps
// V0..VE in two RAM copies (one per read port), VF in a flop, valid bits for reset.
// Depends on c8x_pkg and c8x_ram.
module c8x_regfile (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [c8x_pkg::RIDX_W-1:0] rd_addr_a,
    input  logic [c8x_pkg::RIDX_W-1:0] rd_addr_b,
    input  c8x_pkg::c8x_rf_wr_t        wr,
    output logic [c8x_pkg::REG_W-1:0]  rd_data_a,
    output logic [c8x_pkg::REG_W-1:0]  rd_data_b
);
    import c8x_pkg::*;

    logic [NREGS-1:0]  vld_reg, vld_next;
    logic [REG_W-1:0]  vf_reg, vf_next;
    logic [RIDX_W-1:0] addr_a_reg, addr_b_reg;
    logic              byp_a_reg, byp_b_reg;
    logic              vld_a_reg, vld_b_reg;
    logic [REG_W-1:0]  wr_data_reg;
    logic [REG_W-1:0]  ram_a, ram_b;
    logic              ram_we;

    // VF is written by the flag first, then by the destination write
    assign ram_we = wr.dest_we && (wr.dest_idx != REG_VF);

    always_comb begin
        vld_next = vld_reg;
        if (ram_we) begin
            vld_next[wr.dest_idx] = 1'b1;
        end
        vf_next = vf_reg;
        if (wr.dest_we && (wr.dest_idx == REG_VF)) begin
            vf_next = wr.dest_val;
        end else if (wr.flag_we) begin
            vf_next = {{(REG_W-1){1'b0}}, wr.flag_val};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vf_reg    <= '0;
            byp_a_reg <= 1'b0;
            byp_b_reg <= 1'b0;
        end else begin
            vld_reg   <= vld_next;
            vf_reg    <= vf_next;
            byp_a_reg <= ram_we && (wr.dest_idx == rd_addr_a);
            byp_b_reg <= ram_we && (wr.dest_idx == rd_addr_b);
        end
        addr_a_reg  <= rd_addr_a;
        addr_b_reg  <= rd_addr_b;
        vld_a_reg   <= vld_reg[rd_addr_a];
        vld_b_reg   <= vld_reg[rd_addr_b];
        wr_data_reg <= wr.dest_val;
    end

    c8x_ram #(.WIDTH(REG_W), .DEPTH(NREGS)) u_ram_a (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr.dest_idx),
        .wr_data (wr.dest_val),
        .rd_addr (rd_addr_a),
        .rd_data (ram_a)
    );

    c8x_ram #(.WIDTH(REG_W), .DEPTH(NREGS)) u_ram_b (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr.dest_idx),
        .wr_data (wr.dest_val),
        .rd_addr (rd_addr_b),
        .rd_data (ram_b)
    );

    // Forward a write that landed on the same edge as the read; unwritten reads zero
    always_comb begin
        if (addr_a_reg == REG_VF) begin
            rd_data_a = vf_reg;
        end else if (byp_a_reg) begin
            rd_data_a = wr_data_reg;
        end else if (vld_a_reg) begin
            rd_data_a = ram_a;
        end else begin
            rd_data_a = '0;
        end
        if (addr_b_reg == REG_VF) begin
            rd_data_b = vf_reg;
        end else if (byp_b_reg) begin
            rd_data_b = wr_data_reg;
        end else if (vld_b_reg) begin
            rd_data_b = ram_b;
        end else begin
            rd_data_b = '0;
        end
    end

endmodule

[design/c8x_callstack.sv]
`timescale 1ns / 1ps
// Return-address stack: top entry in a register, the rest in RAM with
// the entry below the top prefetched. Depends on c8x_pkg and c8x_ram.
module c8x_callstack (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  c8x_pkg::c8x_stk_ctl_t ctl,
    output c8x_pkg::c8x_stk_stat_t stat
);
    import c8x_pkg::*;

    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [PC_W-1:0]   top_reg, top_next;
    logic [SP_W-1:0]   below_ptr;
    logic [PC_W-1:0]   below_data;

    always_comb begin
        sp_next  = sp_reg;
        top_next = top_reg;
        if (ctl.push) begin
            sp_next  = sp_reg + SP_W'(1);
            top_next = ctl.push_data;
        end else if (ctl.pop) begin
            sp_next  = sp_reg - SP_W'(1);
            top_next = below_data;
        end
    end

    // Prefetch the entry under the next top
    assign below_ptr = sp_next - SP_W'(2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else begin
            sp_reg <= sp_next;
        end
        top_reg <= top_next;
    end

    c8x_ram #(.WIDTH(PC_W), .DEPTH(STACK_DEPTH)) u_ram (
        .aclk    (aclk),
        .wr_en   (ctl.push),
        .wr_addr (sp_reg[SIDX_W-1:0]),
        .wr_data (ctl.push_data),
        .rd_addr (below_ptr[SIDX_W-1:0]),
        .rd_data (below_data)
    );

    assign stat.empty = (sp_reg == '0);
    assign stat.full  = (sp_reg == SP_W'(STACK_DEPTH));
    assign stat.top   = top_reg;

endmodule

[design/c8x_exec.sv]
`timescale 1ns / 1ps
// Instruction decode and ALU: next PC, register writes, stack requests.
// Depends on c8x_pkg.
module c8x_exec (
    input  logic [15:0]                 instr,
    input  logic [c8x_pkg::REG_W-1:0]   random_byte,
    input  logic [c8x_pkg::REG_W-1:0]   vx,
    input  logic [c8x_pkg::REG_W-1:0]   vy,
    input  logic [c8x_pkg::PC_W-1:0]    pc,
    input  logic [c8x_pkg::PC_W-1:0]    index_in,
    input  c8x_pkg::c8x_stk_stat_t      stk_stat,
    output c8x_pkg::c8x_exec_t          ex
);
    import c8x_pkg::*;

    logic [3:0]        grp;
    logic [RIDX_W-1:0] x;
    logic [3:0]        n;
    logic [REG_W-1:0]  nn;
    logic [PC_W-1:0]   nnn;
    logic [PC_W-1:0]   pc2, pc4;
    logic [REG_W:0]    sum;

    assign grp = instr[15:12];
    assign x   = instr[11:8];
    assign n   = instr[3:0];
    assign nn  = instr[7:0];
    assign nnn = instr[11:0];
    assign pc2 = pc + PC_W'(2);
    assign pc4 = pc + PC_W'(4);
    assign sum = {1'b0, vx} + {1'b0, vy};

    always_comb begin
        ex                 = '0;
        ex.res.next_pc     = pc2;
        ex.res.index_value = index_in;
        ex.stk.push_data   = pc2;
        unique case (grp)
            OP_SYS: begin
                if (n == SYS_CLS) begin
                    ex.res.clear_display = 1'b1;
                end else if (n == SYS_RET) begin
                    if (stk_stat.empty) begin
                        ex.res.stack_error = 1'b1;
                    end else begin
                        ex.stk.pop     = 1'b1;
                        ex.res.next_pc = stk_stat.top;
                    end
                end else begin
                    ex.res.unknown_op = 1'b1;
                end
            end
            OP_JP: ex.res.next_pc = nnn;
            OP_CALL: begin
                if (stk_stat.full) begin
                    ex.res.stack_error = 1'b1;
                end else begin
                    ex.stk.push    = 1'b1;
                    ex.res.next_pc = nnn;
                end
            end
            OP_SEI:  if (vx == nn) ex.res.next_pc = pc4;
            OP_SNEI: if (vx != nn) ex.res.next_pc = pc4;
            OP_SER:  if (vx == vy) ex.res.next_pc = pc4;
            OP_LDI: begin
                ex.rf.dest_we  = 1'b1;
                ex.rf.dest_val = nn;
            end
            OP_ADDI: begin
                ex.rf.dest_we  = 1'b1;
                ex.rf.dest_val = vx + nn;
            end
            OP_ALU: begin
                ex.rf.dest_we = 1'b1;
                unique case (n)
                    ALU_MOV: ex.rf.dest_val = vy;
                    ALU_OR:  ex.rf.dest_val = vx | vy;
                    ALU_AND: ex.rf.dest_val = vx & vy;
                    ALU_XOR: ex.rf.dest_val = vx ^ vy;
                    ALU_ADD: begin
                        ex.rf.flag_we  = 1'b1;
                        ex.rf.flag_val = sum[REG_W];
                        ex.rf.dest_val = sum[REG_W-1:0];
                    end
                    ALU_SUB: begin
                        ex.rf.flag_we  = 1'b1;
                        ex.rf.flag_val = !(vy > vx);
                        ex.rf.dest_val = vx - vy;
                    end
                    ALU_SHR: begin
                        ex.rf.flag_we  = 1'b1;
                        ex.rf.flag_val = vx[0];
                        ex.rf.dest_val = vx >> 1;
                    end
                    ALU_SUBN: begin
                        ex.rf.flag_we  = 1'b1;
                        ex.rf.flag_val = !(vx > vy);
                        ex.rf.dest_val = vy - vx;
                    end
                    default: begin
                        ex.rf.dest_we     = 1'b0;
                        ex.res.unknown_op = 1'b1;
                    end
                endcase
            end
            OP_LDX:  ex.res.index_value = nnn;
            // vx carries V0 here: the register file reads address zero for this group
            OP_JPV0: ex.res.next_pc = {{(PC_W-REG_W){1'b0}}, vx} + nnn;
            OP_RND: begin
                ex.rf.dest_we  = 1'b1;
                ex.rf.dest_val = random_byte & nn;
            end
            default: ex.res.unknown_op = 1'b1;
        endcase

        if (ex.rf.dest_we) begin
            ex.rf.dest_idx = x;
        end
        ex.res.dest_written = ex.rf.dest_we;
        ex.res.dest_index   = ex.rf.dest_idx;
        ex.res.dest_value   = ex.rf.dest_val;
        ex.res.flag_written = ex.rf.flag_we;
        ex.res.flag_value   = ex.rf.flag_val;
    end

endmodule

[design/chip8_instruction_execute_core.sv]
`timescale 1ns / 1ps
// Top level of the CHIP-8 style instruction execute core.
// Depends on c8x_pkg, c8x_regfile, c8x_callstack and c8x_exec.
//
//  Channel  | Direction | Handshake        | Beat contents
//  ---------+-----------+------------------+----------------------------------
//  s_axis   | in        | s_tvalid/tready  | instr, random_byte (24 bits)
//  m_axis   | out       | m_tvalid/tready  | next_pc .. flag_value (48 bits)
//  cfg      | in        | cfg_wr_en        | start_address (12 bits)
//
// One instruction per cycle sustained while m_tready stays high. A beat taken at an edge
// is held in the input register and executes from there (the register file RAMs deliver
// its operands at that edge); its result is registered and then shown on m_tdata.
// The input register and the result register form a two-deep pipeline, so
// a new beat can be taken while a finished result waits for m_tready.
// Synchronous active-low reset empties the pipeline and the call stack, zeroes
// V0..VF and the index and loads the program counter with 0x200. A cfg write
// loads the program counter at once; write only when the core is idle.
module chip8_instruction_execute_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: start_address
    input  logic                           cfg_wr_en,
    input  logic [c8x_pkg::PC_W-1:0]       cfg_wr_data,
    // Instruction stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] instr, [23:16] random_byte
    input  logic [c8x_pkg::IN_DATA_W-1:0]  s_tdata,
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [11:0] next_pc, [23:12] index_value, [24] clear_display, [25] unknown_op,
    // [26] stack_error, [27] dest_written, [31:28] dest_index,
    // [39:32] dest_value, [40] flag_written, [41] flag_value, [47:42] zero
    output logic [c8x_pkg::OUT_DATA_W-1:0] m_tdata
);
    import c8x_pkg::*;

    // Pipeline handshake
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              exec_fire;
    logic              in_load;

    // Input stage payload
    logic [15:0]       instr_reg;
    logic [REG_W-1:0]  rnd_reg;

    // Architectural state kept here
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [PC_W-1:0]   index_reg, index_next;

    // Result register
    c8x_result_t       res_reg;

    // Operand fetch and execute
    logic [15:0]       fetch_instr;
    logic [RIDX_W-1:0] rd_addr_a, rd_addr_b;
    logic [REG_W-1:0]  opnd_a, opnd_b;
    c8x_exec_t         ex;
    c8x_rf_wr_t        rf_wr;
    c8x_stk_ctl_t      stk_ctl;
    c8x_stk_stat_t     stk_stat;

    // Execute when an instruction is staged and the result slot is free or draining
    assign exec_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || exec_fire;
    assign in_load   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_load) begin
            in_valid_next = 1'b1;
        end else if (exec_fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (exec_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Read operands for the beat that will sit in the input register next cycle:
    // the incoming beat on a load, otherwise hold the staged one
    assign fetch_instr = in_load ? s_tdata[15:0] : instr_reg;
    // Jump plus V0 reads V0 in place of VX
    assign rd_addr_a   = (fetch_instr[15:12] == OP_JPV0) ? REG_V0 : fetch_instr[11:8];
    assign rd_addr_b   = fetch_instr[7:4];

    // Commit state changes only on the edge that executes the beat
    assign rf_wr   = exec_fire ? ex.rf  : '0;
    assign stk_ctl = exec_fire ? ex.stk : '0;

    always_comb begin
        pc_next    = pc_reg;
        index_next = index_reg;
        if (cfg_wr_en) begin
            pc_next = cfg_wr_data;
        end else if (exec_fire) begin
            pc_next    = ex.res.next_pc;
            index_next = ex.res.index_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= RESET_START;
            index_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
            index_reg     <= index_next;
        end
        if (in_load) begin
            instr_reg <= s_tdata[15:0];
            rnd_reg   <= s_tdata[23:16];
        end
        if (exec_fire) begin
            res_reg <= ex.res;
        end
    end

    c8x_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr        (rf_wr),
        .rd_data_a (opnd_a),
        .rd_data_b (opnd_b)
    );

    c8x_callstack u_callstack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (stk_ctl),
        .stat    (stk_stat)
    );

    c8x_exec u_exec (
        .instr       (instr_reg),
        .random_byte (rnd_reg),
        .vx          (opnd_a),
        .vy          (opnd_b),
        .pc          (pc_reg),
        .index_in    (index_reg),
        .stk_stat    (stk_stat),
        .ex          (ex)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0,
                       res_reg.flag_value,
                       res_reg.flag_written,
                       res_reg.dest_value,
                       res_reg.dest_index,
                       res_reg.dest_written,
                       res_reg.stack_error,
                       res_reg.unknown_op,
                       res_reg.clear_display,
                       res_reg.index_value,
                       res_reg.next_pc};

endmodule

[test/tb_chip8_instruction_execute_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for chip8_instruction_execute_core: instruction beats in,
// result beats out. Depends on c8x_pkg and the core RTL; holds its own behavioral
// model of the execute unit.
module tb_chip8_instruction_execute_core;

    import c8x_pkg::*;

    // Group codes that the core does not execute (skip-on-register-not-equal,
    // draw, key skips, misc); they must come back flagged as unknown.
    localparam logic [3:0] UNH_SNER = 4'h9;
    localparam logic [3:0] UNH_DRW  = 4'hD;
    localparam logic [3:0] UNH_SKP  = 4'hE;
    localparam logic [3:0] UNH_MISC = 4'hF;

    localparam int CYCLE_LIMIT  = 200_000;
    // Drain wait: the result register sits behind the input register, plus margin.
    localparam int DRAIN_CYCLES = 6;

    typedef enum logic [1:0] {
        RX_FULL,
        RX_COIN,
        RX_QUARTER,
        RX_LONG
    } rx_pattern_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [PC_W-1:0]       cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    // [15:0] instr, [23:16] random_byte
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    // [11:0] next_pc, [23:12] index_value, [24] clear_display, [25] unknown_op,
    // [26] stack_error, [27] dest_written, [31:28] dest_index,
    // [39:32] dest_value, [40] flag_written, [41] flag_value
    logic [OUT_DATA_W-1:0] m_tdata;

    chip8_instruction_execute_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Architectural state of the model: register file, index, program
    // counter and return-address stack.
    // ------------------------------------------------------------------
    logic [REG_W-1:0] gp_reg    [NREGS];
    logic [PC_W-1:0]  index_q;
    logic [PC_W-1:0]  pc_q;
    logic [PC_W-1:0]  ret_stack [STACK_DEPTH];
    int               stack_level;

    c8x_result_t pending_results [$];
    c8x_result_t want_res;
    int          mismatch_count = 0;
    int          cycle_cnt      = 0;
    int          burst_left     = 0;

    rx_pattern_t rx_mode = RX_FULL;
    int          rx_span = 0;

    // Execute one instruction against the model state and return the
    // result beat the core must produce for it.
    function automatic c8x_result_t execute_instr(input logic [15:0] ins,
                                                  input logic [7:0]  rnd);
        logic [3:0]       grp, x, y, n;
        logic [7:0]       nn, vx, vy, val;
        logic [8:0]       sum;
        logic [PC_W-1:0]  nnn, npc;
        logic             dw, fw, fv;
        c8x_result_t      r;
        grp = ins[15:12];
        x   = ins[11:8];
        y   = ins[7:4];
        n   = ins[3:0];
        nn  = ins[7:0];
        nnn = ins[11:0];
        vx  = gp_reg[x];
        vy  = gp_reg[y];
        npc = pc_q + 12'd2;
        dw  = 1'b0;
        fw  = 1'b0;
        fv  = 1'b0;
        val = '0;
        r   = '0;
        case (grp)
            OP_SYS: begin
                if (n == SYS_CLS) begin
                    r.clear_display = 1'b1;
                end else if (n == SYS_RET) begin
                    if (stack_level == 0) begin
                        r.stack_error = 1'b1;
                    end else begin
                        stack_level--;
                        npc = ret_stack[stack_level];
                    end
                end else begin
                    r.unknown_op = 1'b1;
                end
            end
            OP_JP: npc = nnn;
            OP_CALL: begin
                if (stack_level >= STACK_DEPTH) begin
                    r.stack_error = 1'b1;
                end else begin
                    ret_stack[stack_level] = npc;
                    stack_level++;
                    npc = nnn;
                end
            end
            OP_SEI:  if (vx == nn) npc = pc_q + 12'd4;
            OP_SNEI: if (vx != nn) npc = pc_q + 12'd4;
            OP_SER:  if (vx == vy) npc = pc_q + 12'd4;
            OP_LDI: begin
                dw  = 1'b1;
                val = nn;
            end
            OP_ADDI: begin
                dw  = 1'b1;
                val = vx + nn;
            end
            OP_ALU: begin
                case (n)
                    ALU_MOV: begin dw = 1'b1; val = vy;      end
                    ALU_OR:  begin dw = 1'b1; val = vx | vy; end
                    ALU_AND: begin dw = 1'b1; val = vx & vy; end
                    ALU_XOR: begin dw = 1'b1; val = vx ^ vy; end
                    ALU_ADD: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        fw  = 1'b1;
                        fv  = sum[8];
                        dw  = 1'b1;
                        val = sum[7:0];
                    end
                    ALU_SUB: begin
                        fw  = 1'b1;
                        fv  = (vy > vx) ? 1'b0 : 1'b1;
                        dw  = 1'b1;
                        val = vx - vy;
                    end
                    ALU_SHR: begin
                        fw  = 1'b1;
                        fv  = vx[0];
                        dw  = 1'b1;
                        val = vx >> 1;
                    end
                    ALU_SUBN: begin
                        fw  = 1'b1;
                        fv  = (vx > vy) ? 1'b0 : 1'b1;
                        dw  = 1'b1;
                        val = vy - vx;
                    end
                    default: r.unknown_op = 1'b1;
                endcase
            end
            OP_LDX:  index_q = nnn;
            OP_JPV0: npc = {4'h0, gp_reg[REG_V0]} + nnn;
            OP_RND: begin
                dw  = 1'b1;
                val = rnd & nn;
            end
            default: r.unknown_op = 1'b1;
        endcase
        // Flag lands first, so a VX write to VF overrides it.
        if (fw) gp_reg[REG_VF] = {7'd0, fv};
        if (dw) gp_reg[x] = val;
        pc_q = npc;
        r.next_pc       = npc;
        r.index_value   = index_q;
        r.dest_written  = dw;
        r.dest_index    = dw ? x : '0;
        r.dest_value    = val;
        r.flag_written  = fw;
        r.flag_value    = fv;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between bursts. Valid
    // stays high across back-to-back beats; it drops only in a gap.
    // ------------------------------------------------------------------
    task automatic send_instr(input logic [15:0] ins, input logic [7:0] rnd);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rnd, ins};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(execute_instr(ins, rnd));
        burst_left--;
    endtask

    // Write the entry point. Drain the core first: the write reloads the
    // program counter immediately.
    task automatic set_start(input logic [PC_W-1:0] addr);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        pc_q = addr;
    endtask

    // ------------------------------------------------------------------
    // Test: one beat per operation, plus the corner cases.
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_instr(16'h00E0, 8'h00);                     // clear screen
        send_instr(16'h00EE, 8'hFF);                     // return, stack empty
        send_instr(16'h0FF5, 8'h00);                     // group zero, bad sub-code
        send_instr(16'h60FF, 8'hFF);                     // V0 = FF
        send_instr(16'h7001, 8'h00);                     // add immediate wraps to 00
        send_instr(16'h6180, 8'h00);
        send_instr(16'h6280, 8'h00);
        send_instr({OP_ALU, 8'h12, ALU_ADD}, 8'h00);     // 80+80: carry out
        send_instr({OP_ALU, 8'h12, ALU_SUB}, 8'h00);     // 00-80: borrow
        send_instr({OP_ALU, 8'h21, ALU_SHR}, 8'h00);     // shift uses VX, not VY
        send_instr({OP_ALU, 8'h12, ALU_SUBN}, 8'h00);
        send_instr(16'h6FFF, 8'h00);
        send_instr({OP_ALU, 8'hFF, ALU_ADD}, 8'h00);     // VF as target: result wins
        send_instr({OP_ALU, 8'hF0, ALU_SHR}, 8'h00);
        send_instr({OP_ALU, 8'h12, ALU_MOV}, 8'h00);
        send_instr({OP_ALU, 8'h1F, ALU_OR}, 8'h00);
        send_instr({OP_ALU, 8'h21, ALU_AND}, 8'h00);
        send_instr({OP_ALU, 8'h2F, ALU_XOR}, 8'h00);
        send_instr({OP_ALU, 8'h12, 4'h8}, 8'h00);        // ALU sub-codes 8..F unused
        send_instr({OP_ALU, 8'hFF, 4'hF}, 8'hFF);
        send_instr({UNH_SNER, 12'h120}, 8'h00);
        send_instr({UNH_DRW, 12'h123}, 8'h00);
        send_instr({UNH_SKP, 12'h19E}, 8'h00);
        send_instr({UNH_MISC, 12'h165}, 8'h00);
        send_instr({OP_LDX, 12'hFFF}, 8'h00);
        send_instr(16'h6005, 8'h00);
        send_instr({OP_JPV0, 12'hFFE}, 8'h00);           // V0 + NNN wraps
        send_instr({OP_SEI, 12'h005}, 8'h00);            // taken skip
        send_instr({OP_SNEI, 12'h006}, 8'h00);           // taken skip
        send_instr({OP_SER, 12'h010}, 8'h00);
        send_instr({OP_RND, 12'h3A5}, 8'hFF);
        send_instr({OP_RND, 12'h3FF}, 8'h5A);
        send_instr({OP_JP, 12'hFFE}, 8'h00);
        send_instr({OP_CALL, 12'hABC}, 8'h00);           // pushes wrapped 000
        send_instr({OP_SYS, 8'h00, SYS_RET}, 8'h00);
    endtask

    // ------------------------------------------------------------------
    // Test: fill the return stack, call once more, then empty it and
    // return once more. Both extra beats must raise stack_error.
    // ------------------------------------------------------------------
    task automatic test_call_stack();
        while (stack_level < STACK_DEPTH)
            send_instr({OP_CALL, 12'($urandom_range(0, 4095))}, 8'($urandom_range(0, 255)));
        send_instr({OP_CALL, 12'($urandom_range(0, 4095))}, 8'h00);
        while (stack_level > 0)
            send_instr({OP_SYS, 8'($urandom_range(0, 255)), SYS_RET}, 8'h00);
        send_instr({OP_SYS, 8'h00, SYS_RET}, 8'h00);
    endtask

    // ------------------------------------------------------------------
    // Test: random program. Mostly valid instructions with random operands;
    // skips often compare against the live register value so both outcomes
    // occur; runs of calls and returns walk the stack to both ends.
    // ------------------------------------------------------------------
    task automatic test_random_program(input int n_items);
        int          sent;
        int          kind;
        int          run;
        logic [3:0]  x, y;
        logic [7:0]  nn, rnd;
        logic [15:0] ins;
        sent = 0;
        while (sent < n_items) begin
            x    = 4'($urandom_range(0, 15));
            y    = 4'($urandom_range(0, 15));
            nn   = 8'($urandom_range(0, 255));
            rnd  = 8'($urandom_range(0, 255));
            kind = $urandom_range(0, 99);
            if (kind < 4) begin
                run = $urandom_range(1, STACK_DEPTH + 2);
                repeat (run) send_instr({OP_CALL, 12'($urandom_range(0, 4095))}, rnd);
                sent += run;
                continue;
            end
            if (kind < 8) begin
                run = $urandom_range(1, STACK_DEPTH + 2);
                repeat (run) send_instr({OP_SYS, 8'($urandom_range(0, 255)), SYS_RET}, rnd);
                sent += run;
                continue;
            end
            if (kind < 14)      ins = 16'($urandom_range(0, 16'hFFFF));
            else if (kind < 17) ins = {OP_SYS, nn, SYS_CLS};
            else if (kind < 20) ins = {OP_SYS, nn, 4'($urandom_range(1, 13))};
            else if (kind < 25) ins = {OP_JP, 12'($urandom_range(0, 4095))};
            else if (kind < 29) ins = {OP_CALL, 12'($urandom_range(0, 4095))};
            else if (kind < 33) ins = {OP_SYS, nn, SYS_RET};
            else if (kind < 39) begin
                if ($urandom_range(0, 1)) nn = gp_reg[x];
                ins = {OP_SEI, x, nn};
            end else if (kind < 45) begin
                if ($urandom_range(0, 1)) nn = gp_reg[x];
                ins = {OP_SNEI, x, nn};
            end else if (kind < 50) begin
                if ($urandom_range(0, 1)) y = x;
                ins = {OP_SER, x, y, 4'h0};
            end
            else if (kind < 62) ins = {OP_LDI, x, nn};
            else if (kind < 68) ins = {OP_ADDI, x, nn};
            else if (kind < 84) begin
                // Target the flag register now and then.
                if ($urandom_range(0, 7) == 0) x = REG_VF;
                ins = {OP_ALU, x, y, 4'($urandom_range(0, 7))};
            end
            else if (kind < 87) ins = {OP_ALU, x, y, 4'($urandom_range(8, 15))};
            else if (kind < 90) ins = {OP_LDX, 12'($urandom_range(0, 4095))};
            else if (kind < 93) ins = {OP_JPV0, 12'($urandom_range(0, 4095))};
            else if (kind < 97) ins = {OP_RND, x, nn};
            else begin
                case ($urandom_range(0, 3))
                    0:       ins = {UNH_SNER, x, y, 4'h0};
                    1:       ins = {UNH_DRW,  x, nn};
                    2:       ins = {UNH_SKP,  x, nn};
                    default: ins = {UNH_MISC, x, nn};
                endcase
            end
            send_instr(ins, rnd);
            sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: m_tready follows a pattern picked at random for a random span:
    // always ready, coin flip, one in four, or long stalls.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b1;
        end else begin
            if (rx_span == 0) begin
                rx_mode <= rx_pattern_t'($urandom_range(0, 3));
                rx_span <= $urandom_range(16, 96);
            end else begin
                rx_span <= rx_span - 1;
            end
            case (rx_mode)
                RX_FULL:    m_tready <= 1'b1;
                RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
                RX_QUARTER: m_tready <= (cycle_cnt[1:0] == 2'b00);
                default:    m_tready <= (cycle_cnt[4:3] != 2'b11);
            endcase
        end
    end

    // Compare one field and count the mismatch.
    function automatic void check_field(input string name, input int unsigned want_v,
                                        input int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    // Check each result beat against the oldest pending prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no prediction pending: m_tdata=0x%0h", m_tdata);
                mismatch_count++;
            end else begin
                want_res = pending_results.pop_front();
                check_field("next_pc",       want_res.next_pc,       m_tdata[11:0]);
                check_field("index_value",   want_res.index_value,   m_tdata[23:12]);
                check_field("clear_display", want_res.clear_display, m_tdata[24]);
                check_field("unknown_op",    want_res.unknown_op,    m_tdata[25]);
                check_field("stack_error",   want_res.stack_error,   m_tdata[26]);
                check_field("dest_written",  want_res.dest_written,  m_tdata[27]);
                check_field("dest_index",    want_res.dest_index,    m_tdata[31:28]);
                check_field("dest_value",    want_res.dest_value,    m_tdata[39:32]);
                check_field("flag_written",  want_res.flag_written,  m_tdata[40]);
                check_field("flag_value",    want_res.flag_value,    m_tdata[41]);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        // Model comes up as the core does after reset.
        for (int i = 0; i < NREGS; i++) gp_reg[i] = '0;
        for (int i = 0; i < STACK_DEPTH; i++) ret_stack[i] = '0;
        index_q     = '0;
        pc_q        = RESET_START;
        stack_level = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        set_start(12'hFFF);          // top of memory: pushed return addresses wrap
        test_call_stack();
        set_start(12'h000);
        test_random_program(170);
        set_start(12'($urandom_range(0, 4095)));
        test_random_program(170);

        // Drop valid, drain, then let the pipeline settle.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
